FILE: hw/rtl/csc_pkg.sv
// Shared types, codes and constants of the curve sweep capture sequencer.
// Used by the top level and its port checker; depends on nothing else.
`default_nettype none

package csc_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int SAMPLE_W   = 10;
    localparam int GRID_W     = 8;
    localparam int VALUE_W    = 9;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_ADDR_W = 1;

    // Defaults of the top-level parameters.
    localparam int BUF_DEPTH_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 10;

    // Highest grid setting in tenths of a volt.
    localparam logic [GRID_W-1:0] MAX_GRID = 8'd100;

    // A sweep begins only when the previous sample is below this level.
    localparam int EDGE_LIMIT = 100;

    // At most this many curve points leave one sweep.
    localparam int ITEM_LIMIT = 32;

    // Sample scale factor: 505/2048 for summed pairs, 505/1024 for single samples.
    localparam int SCALE     = 505;
    localparam int PAIR_SHR  = 11;
    localparam int ODD_SHR   = 10;
    localparam int VALUE_MAX = 511;

    // 2^19/100 rounded up; exact floor division by 100 for every x up to 25500.
    localparam logic [12:0] DUTY_RECIP = 13'd5243;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRID_START = 1'b0,
        REG_GRID_STEP  = 1'b1
    } cfg_reg_t;

    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STARTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POINT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd3;

    // PWM duty for a grid setting: setting * 255 / 100, valid for settings up to 100.
    function automatic logic [GRID_W-1:0] duty_of(input logic [GRID_W-1:0] g);
        logic [15:0] x;
        logic [28:0] p;
        x = {g, 8'd0} - {8'd0, g};
        p = 29'(x) * 29'(DUTY_RECIP);
        return p[26:19];
    endfunction

    localparam logic [GRID_W-1:0] DUTY_FULL = duty_of(MAX_GRID);

endpackage

`default_nettype wire

FILE: hw/rtl/curve_sweep_capture_sequencer.sv
// Top level of the curve sweep capture sequencer: sweep control, sample store
// and the point formation sequencer around one shared scaling multiplier.
// Depends on csc_pkg.
`default_nettype none

// A start word returns one word. A sample word that does not end a sweep returns
// nothing. A sample word that ends a sweep returns one word per point, or one empty
// word for a sweep without points; the output side can stall these words. The
// sample store has a single registered read port, and each point needs two reads
// and two passes through the one 505x multiplier.
// The block does not accept words while a sweep end is being worked off. The
// sample store needs no clearing after reset; only entries written in the
// current sweep are read.
module curve_sweep_capture_sequencer
    import csc_pkg::*;
#(
    parameter int BUF_DEPTH   = BUF_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [GRID_W-1:0]     cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,    // [9:0] sample, rest zero
    input  wire logic                  s_tuser,    // [0] mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,    // [7:0] grid_setting, [16:8] anode_value,
                                                   // [25:17] second_value, [33:26] duty,
                                                   // [34] finished, rest zero
    output logic [STATUS_W-1:0]        m_tuser,    // [1:0] status
    output logic                       m_tlast
);

    localparam int SW = SAMPLE_BITS;
    localparam int EW = (SW > SAMPLE_W) ? SW : SAMPLE_W;
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int AW = $clog2(BUF_DEPTH);
    localparam int PW = SW + 10;
    localparam int NW = $clog2(ITEM_LIMIT);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EMIT  = 9'b000000010,
        S_END   = 9'b000000100,
        S_FIRST = 9'b000001000,
        S_ODD   = 9'b000010000,
        S_EVEN  = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_EMPTY = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [GRID_W-1:0] grid_start_reg;
    logic [GRID_W-1:0] grid_step_reg;

    logic              running_reg;
    logic              capturing_reg;
    logic              have_prev_reg;
    logic [SW-1:0]     prev_reg;
    logic [CW-1:0]     count_reg;
    logic [GRID_W-1:0] grid_reg;
    logic [GRID_W-1:0] sweep_grid_reg;
    logic              fin_reg;
    logic              refused_reg;
    logic [CW-1:0]     ptr_reg;
    logic [NW-1:0]     pts_reg;

    logic [SW-1:0]     even_reg;
    logic [SW-1:0]     odd_reg;
    logic [SW-1:0]     next_even_reg;
    logic [PW-1:0]     prod_a_reg;
    logic [PW-1:0]     prod_b_reg;

    logic [SW-1:0]     mem [BUF_DEPTH];
    logic [SW-1:0]     rd_data_reg;
    logic [CW-1:0]     rd_addr;
    logic              mem_we;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [GRID_W-1:0]   out_grid_reg;
    logic [VALUE_W-1:0]  out_anode_reg;
    logic [VALUE_W-1:0]  out_second_reg;
    logic [GRID_W-1:0]   out_duty_reg;
    logic                out_fin_reg;
    logic                out_last_reg;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic [EW-1:0]     s_wide;
    logic [SW-1:0]     s_val;
    logic [SW-1:0]     prev_eff;
    logic [CW-1:0]     cnt_inc;
    logic              sweep_done;
    logic [CW-1:0]     c_even;
    logic [GRID_W-1:0] start_grid;
    logic [GRID_W-1:0] step_eff;
    logic [GRID_W-1:0] grid_lowered;
    logic [GRID_W-1:0] duty_now;
    logic              pair_at_end;
    logic              point_last;
    logic [SW-1:0]     even_nxt;
    logic [SW:0]       mul_in;
    logic [PW-1:0]     mul_out;
    logic [PW-1:0]     a_shift;
    logic [PW-1:0]     b_shift;
    logic [VALUE_W-1:0] anode_sat;
    logic [VALUE_W-1:0] second_sat;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = out_free && ((state_reg == S_EMIT) || (state_reg == S_OUT)
                                    || (state_reg == S_EMPTY));

    assign s_wide = EW'(s_tdata[SAMPLE_W-1:0]);
    assign s_val  = s_wide[SW-1:0];

    // The first sample of a run is compared against itself.
    assign prev_eff   = have_prev_reg ? prev_reg : s_val;
    assign cnt_inc    = count_reg + CW'(1);
    assign sweep_done = (cnt_inc[0] && (prev_eff > s_val)) || (cnt_inc >= CW'(BUF_DEPTH));
    assign c_even     = {count_reg[CW-1:1], 1'b0};

    assign start_grid   = (grid_start_reg > MAX_GRID) ? MAX_GRID : grid_start_reg;
    assign step_eff     = (grid_step_reg == '0) ? GRID_W'(1) : grid_step_reg;
    assign grid_lowered = (grid_reg > step_eff) ? (grid_reg - step_eff) : '0;
    assign duty_now     = duty_of(grid_reg);

    // The last pair reuses the even sample before it in place of the one that ended the sweep.
    assign pair_at_end = (CW'(ptr_reg + CW'(2)) == c_even);
    assign point_last  = pair_at_end || (pts_reg == NW'(ITEM_LIMIT - 1));
    assign even_nxt    = pair_at_end ? even_reg : rd_data_reg;

    assign mul_in  = (state_reg == S_EVEN) ? ((SW+1)'(even_reg) + (SW+1)'(even_nxt))
                                           : (SW+1)'(odd_reg);
    assign mul_out = PW'(mul_in) * PW'(SCALE);

    assign a_shift    = prod_a_reg >> PAIR_SHR;
    assign b_shift    = prod_b_reg >> ODD_SHR;
    assign anode_sat  = (a_shift > PW'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX) : a_shift[VALUE_W-1:0];
    assign second_sat = (b_shift > PW'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX) : b_shift[VALUE_W-1:0];

    assign mem_we = in_accept && (s_tuser == MODE_SAMPLE) && running_reg && capturing_reg
                    && (count_reg < CW'(BUF_DEPTH));

    always_comb
    begin
        rd_addr = CW'(ptr_reg + CW'(3));
        if (state_reg == S_END)
        begin
            rd_addr = CW'(2);
        end
        else if (state_reg == S_FIRST)
        begin
            rd_addr = CW'(ptr_reg + CW'(1));
        end
        else if (state_reg == S_ODD)
        begin
            rd_addr = CW'(ptr_reg + CW'(2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= s_val;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == MODE_START)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (running_reg && capturing_reg && sweep_done)
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                state_next = (c_even >= CW'(4)) ? S_FIRST : S_EMPTY;
            end
            S_FIRST: state_next = S_ODD;
            S_ODD:   state_next = S_EVEN;
            S_EVEN:  state_next = S_MUL;
            S_MUL:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = point_last ? S_IDLE : S_ODD;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Configuration and sweep control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            grid_start_reg <= '0;
            grid_step_reg  <= GRID_W'(10);
            running_reg    <= 1'b0;
            capturing_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            prev_reg       <= '0;
            count_reg      <= '0;
            grid_reg       <= '0;
            sweep_grid_reg <= '0;
            fin_reg        <= 1'b0;
            refused_reg    <= 1'b0;
            ptr_reg        <= '0;
            pts_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_GRID_START: grid_start_reg <= cfg_wr_data;
                    REG_GRID_STEP:  grid_step_reg  <= cfg_wr_data;
                endcase
            end

            // A new word is loaded whenever the output register is free and a word is ready.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && (s_tuser == MODE_START))
                    begin
                        refused_reg <= (start_grid == '0);
                        if (start_grid != '0)
                        begin
                            running_reg   <= 1'b1;
                            capturing_reg <= 1'b0;
                            have_prev_reg <= 1'b0;
                            prev_reg      <= '0;
                            count_reg     <= '0;
                            grid_reg      <= start_grid;
                        end
                    end
                    else if (in_accept && running_reg)
                    begin
                        have_prev_reg <= 1'b1;
                        if (!capturing_reg)
                        begin
                            if ((prev_eff < SW'(EDGE_LIMIT)) && (s_val > prev_eff))
                            begin
                                capturing_reg <= 1'b1;
                            end
                            prev_reg <= s_val;
                        end
                        else
                        begin
                            count_reg <= cnt_inc;
                            if (cnt_inc[0])
                            begin
                                prev_reg <= s_val;
                            end
                        end
                    end
                end
                S_END:
                begin
                    sweep_grid_reg <= grid_reg;
                    capturing_reg  <= 1'b0;
                    ptr_reg        <= CW'(2);
                    pts_reg        <= '0;
                    if (grid_reg == '0)
                    begin
                        running_reg <= 1'b0;
                        fin_reg     <= 1'b1;
                    end
                    else
                    begin
                        grid_reg <= grid_lowered;
                        fin_reg  <= 1'b0;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        if (point_last)
                        begin
                            count_reg <= '0;
                        end
                        else
                        begin
                            ptr_reg <= CW'(ptr_reg + CW'(2));
                            pts_reg <= pts_reg + NW'(1);
                        end
                    end
                end
                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        count_reg <= '0;
                    end
                end
                S_EMIT, S_FIRST, S_ODD, S_EVEN, S_MUL:
                begin
                end
            endcase
        end
    end

    // Point datapath and output word; no reset needed.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_FIRST:
            begin
                even_reg <= rd_data_reg;
            end
            S_ODD:
            begin
                odd_reg <= rd_data_reg;
            end
            S_EVEN:
            begin
                next_even_reg <= even_nxt;
                prod_a_reg    <= mul_out;
            end
            S_MUL:
            begin
                prod_b_reg <= mul_out;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_status_reg <= refused_reg ? ST_REFUSED : ST_STARTED;
                    out_grid_reg   <= refused_reg ? '0 : grid_reg;
                    out_anode_reg  <= '0;
                    out_second_reg <= '0;
                    out_duty_reg   <= refused_reg ? '0 : duty_now;
                    out_fin_reg    <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_status_reg <= ST_POINT;
                    out_grid_reg   <= sweep_grid_reg;
                    out_anode_reg  <= anode_sat;
                    out_second_reg <= second_sat;
                    out_duty_reg   <= fin_reg ? DUTY_FULL : duty_now;
                    out_fin_reg    <= fin_reg;
                    out_last_reg   <= point_last;
                    even_reg       <= next_even_reg;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_status_reg <= ST_EMPTY;
                    out_grid_reg   <= sweep_grid_reg;
                    out_anode_reg  <= '0;
                    out_second_reg <= '0;
                    out_duty_reg   <= fin_reg ? DUTY_FULL : duty_now;
                    out_fin_reg    <= fin_reg;
                    out_last_reg   <= 1'b1;
                end
            end
            S_IDLE, S_END:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_fin_reg, out_duty_reg, out_second_reg, out_anode_reg,
                       out_grid_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/csc_checker.sv
// Port-level checker for the curve sweep capture sequencer and its bind.
// Depends on csc_pkg and the top level curve_sweep_capture_sequencer.
`default_nettype none

module csc_checker
    import csc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [STATUS_W-1:0]   m_tuser,
    input wire logic                  m_tlast
);

    // A refused start carries nothing but its status.
    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_REFUSED)) |-> (m_tlast && (m_tdata[34:0] == '0)))
        else $error("refused word carries data");

    // A start acknowledgment is a single word and never reports the end of a run.
    a_start_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_STARTED)) |-> (m_tlast && !m_tdata[34]))
        else $error("start word malformed");

    // A sweep without points is a single word with zero values.
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_EMPTY)) |-> (m_tlast && (m_tdata[25:8] == '0)))
        else $error("empty sweep word malformed");

    // The block is busy in the cycle after it takes a start word.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_START)) |=> !s_tready)
        else $error("ready right after start");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output word changed");

endmodule

bind curve_sweep_capture_sequencer csc_checker u_csc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
